// ===== rtl/ppr36_pkg.sv =====
// ppr36_pkg: shared types, constants and lookup functions for the packed
// plate radix-36 decoder. No dependencies.

package ppr36_pkg;

	localparam int PLATE_W = 36;
	localparam int HALF_W = 18;
	localparam int HI_W = PLATE_W - HALF_W;
	localparam int QH_W = 13;
	localparam int CHAR_W = 7;
	localparam int NUM_DIG = 5;
	localparam int DIG_W = 6;

	// floor(x / 36) == (x * RECIP36) >> RECIP36_SH for x < 2**24
	localparam int RECIP36_W = 25;
	localparam logic [RECIP36_W-1:0] RECIP36 = 25'd29826162;
	localparam int RECIP36_SH = 30;

	// floor(x / 26) == (x * RECIP26) >> RECIP26_SH for x < 2**11
	localparam int Q26_IN_W = 11;
	localparam int RECIP26_W = 12;
	localparam logic [RECIP26_W-1:0] RECIP26 = 12'd2521;
	localparam int RECIP26_SH = 16;
	localparam int Q26_W = 6;
	localparam int IDX_W = 5;
	localparam int LET_W = 5;
	localparam int UTF8_W = 24;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_A = 7'd65;
	localparam logic [CHAR_W-1:0] ASCII_A_LESS10 = 7'd55;

	typedef logic [NUM_DIG-1:0][CHAR_W-1:0] ppr36_chars_t;

	typedef struct packed {
		logic [PLATE_W-1:0] value;
		ppr36_chars_t       chars;
	} ppr36_word_t;

	// (36 * q) mod 64
	function automatic logic [DIG_W-1:0] mul36_lo6(input logic [DIG_W-1:0] q);
		mul36_lo6 = {q[0], 5'b0} + {q[3:0], 2'b0};
	endfunction

	// (26 * q) mod 32
	function automatic logic [LET_W-1:0] mul26_lo5(input logic [LET_W-1:0] q);
		mul26_lo5 = {q[0], 4'b0} + {q[1:0], 3'b0} + {q[3:0], 1'b0};
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
		if (d < DIG_W'(10)) begin
			digit_char = ASCII_ZERO + CHAR_W'(d);
		end else begin
			digit_char = ASCII_A_LESS10 + CHAR_W'(d);
		end
	endfunction

	function automatic logic [UTF8_W-1:0] province_code(input logic [IDX_W-1:0] idx);
		unique case (idx)
			5'd0:  province_code = 24'hE7B2A4;
			5'd1:  province_code = 24'hE6B998;
			5'd2:  province_code = 24'hE4BAAC;
			5'd3:  province_code = 24'hE6B4A5;
			5'd4:  province_code = 24'hE6B2AA;
			5'd5:  province_code = 24'hE6B89D;
			5'd6:  province_code = 24'hE58680;
			5'd7:  province_code = 24'hE8B1AB;
			5'd8:  province_code = 24'hE4BA91;
			5'd9:  province_code = 24'hE8BEBD;
			5'd10: province_code = 24'hE9BB91;
			5'd11: province_code = 24'hE79A96;
			5'd12: province_code = 24'hE9B281;
			5'd13: province_code = 24'hE696B0;
			5'd14: province_code = 24'hE88B8F;
			5'd15: province_code = 24'hE6B599;
			5'd16: province_code = 24'hE8B5A3;
			5'd17: province_code = 24'hE98482;
			5'd18: province_code = 24'hE6A182;
			5'd19: province_code = 24'hE79498;
			5'd20: province_code = 24'hE6998B;
			5'd21: province_code = 24'hE89299;
			5'd22: province_code = 24'hE99995;
			5'd23: province_code = 24'hE59089;
			5'd24: province_code = 24'hE997BD;
			5'd25: province_code = 24'hE8B4B5;
			5'd26: province_code = 24'hE99D92;
			5'd27: province_code = 24'hE8978F;
			5'd28: province_code = 24'hE5B79D;
			5'd29: province_code = 24'hE5AE81;
			5'd30: province_code = 24'hE790BC;
			5'd31: province_code = 24'hE58FB0;
		endcase
	endfunction

endpackage

// ===== rtl/ppr36_plate_if.sv =====
// ppr36_plate_if: input channel carrying one packed plate word.
// Depends on ppr36_pkg.

interface ppr36_plate_if import ppr36_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PLATE_W-1:0] packed_plate;

	modport source (output valid, output packed_plate, input ready);
	modport sink (input valid, input packed_plate, output ready);
endinterface

// ===== rtl/ppr36_result_if.sv =====
// ppr36_result_if: output channel carrying one decoded plate word.
// Depends on ppr36_pkg.

interface ppr36_result_if import ppr36_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  province_index;
	logic [UTF8_W-1:0] province_utf8;
	logic [CHAR_W-1:0] series_letter;
	logic [CHAR_W-1:0] serial_char_1;
	logic [CHAR_W-1:0] serial_char_2;
	logic [CHAR_W-1:0] serial_char_3;
	logic [CHAR_W-1:0] serial_char_4;
	logic [CHAR_W-1:0] serial_char_5;

	modport source (
		output valid, output province_index, output province_utf8,
		output series_letter, output serial_char_1, output serial_char_2,
		output serial_char_3, output serial_char_4, output serial_char_5,
		input ready
	);
	modport sink (
		input valid, input province_index, input province_utf8,
		input series_letter, input serial_char_1, input serial_char_2,
		input serial_char_3, input serial_char_4, input serial_char_5,
		output ready
	);
endinterface

// ===== rtl/packed_plate_radix36_decoder.sv =====
// Packed plate radix-36 decoder: takes one 36-bit packed plate per word and
// returns its five serial characters, series letter and province code. Five
// divide-by-36 cells of two stages each feed a divide-by-26 and table stage,
// and one plate can enter every cycle while results are taken; each stage
// holds its own word and moves on its own handshake, so the block keeps
// taking plates while a result waits until its stages are full. No state
// survives a word; reset only empties the pipeline.
// Depends on ppr36_pkg, ppr36_plate_if, ppr36_result_if, ppr36_cell, ppr36_tail.

module packed_plate_radix36_decoder import ppr36_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	ppr36_plate_if.sink    plate,
	ppr36_result_if.source result
);

	logic [NUM_DIG:0] link_valid;
	logic [NUM_DIG:0] link_ready;
	ppr36_word_t      link_word [NUM_DIG+1];

	assign link_valid[0]      = plate.valid;
	assign plate.ready        = link_ready[0];
	assign link_word[0].value = plate.packed_plate;
	assign link_word[0].chars = '0;

	for (genvar i = 0; i < NUM_DIG; i++) begin : g_cell
		ppr36_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_word   (link_word[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_word  (link_word[i+1])
		);
	end

	ppr36_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link_valid[NUM_DIG]),
		.in_ready (link_ready[NUM_DIG]),
		.in_word  (link_word[NUM_DIG]),
		.result   (result)
	);

	// empty output stage means the whole chain can advance
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> plate.ready)
		else $error("input stalled with empty output stage");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.series_letter >= ASCII_A &&
			result.series_letter <= 7'd90))
		else $error("series letter out of range");

	a_char1_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.serial_char_1 >= ASCII_ZERO &&
			result.serial_char_1 <= 7'd57) ||
			(result.serial_char_1 >= ASCII_A && result.serial_char_1 <= 7'd90)))
		else $error("serial char 1 out of range");

	a_char5_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.serial_char_5 >= ASCII_ZERO &&
			result.serial_char_5 <= 7'd57) ||
			(result.serial_char_5 >= ASCII_A && result.serial_char_5 <= 7'd90)))
		else $error("serial char 5 out of range");

endmodule

// ===== rtl/ppr36_cell.sv =====
// ppr36_cell: one divide-by-36 cell, two register stages. Emits quotient and
// shifts the remainder character into the character vector. Depends on ppr36_pkg.

module ppr36_cell import ppr36_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ppr36_word_t in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output ppr36_word_t out_word
);

	logic                        valid_s1, valid_s2;
	logic                        ready_s1, ready_s2;
	logic [QH_W-1:0]             qh_s1;
	logic [DIG_W-1:0]            hlo_s1;
	logic [HALF_W-1:0]           lo_s1;
	ppr36_chars_t                chars_s1;
	logic [PLATE_W-1:0]          q_s2;
	logic [DIG_W-1:0]            xlo_s2;
	ppr36_chars_t                chars_s2;

	logic [HI_W-1:0]             hi;
	logic [HI_W+RECIP36_W-1:0]   prod_h;
	logic [DIG_W-1:0]            rh;
	logic [DIG_W+HALF_W-1:0]     x;
	logic [DIG_W+HALF_W+RECIP36_W-1:0] prod_l;
	logic [DIG_W-1:0]            digit;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// high half quotient
	assign hi = in_word.value[PLATE_W-1:HALF_W];
	assign prod_h = {{RECIP36_W{1'b0}}, hi} * {{HI_W{1'b0}}, RECIP36};

	// remainder of high half joined with low half
	assign rh = hlo_s1 - mul36_lo6(qh_s1[DIG_W-1:0]);
	assign x = {rh, lo_s1};
	assign prod_l = {{RECIP36_W{1'b0}}, x} * {{(DIG_W+HALF_W){1'b0}}, RECIP36};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			qh_s1    <= prod_h[RECIP36_SH +: QH_W];
			hlo_s1   <= hi[DIG_W-1:0];
			lo_s1    <= in_word.value[HALF_W-1:0];
			chars_s1 <= in_word.chars;
		end
		if (ready_s2 && valid_s1) begin
			q_s2     <= {{(PLATE_W-HALF_W-QH_W){1'b0}}, qh_s1,
				prod_l[RECIP36_SH +: HALF_W]};
			xlo_s2   <= lo_s1[DIG_W-1:0];
			chars_s2 <= chars_s1;
		end
	end

	assign digit = xlo_s2 - mul36_lo6(q_s2[DIG_W-1:0]);

	assign out_valid      = valid_s2;
	assign out_word.value = q_s2;
	assign out_word.chars = {digit_char(digit), chars_s2[NUM_DIG-1:1]};

endmodule

// ===== rtl/ppr36_tail.sv =====
// ppr36_tail: divide-by-26 letter stage, province lookup and output register.
// Depends on ppr36_pkg and ppr36_result_if.

module ppr36_tail import ppr36_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ppr36_word_t in_word,
	ppr36_result_if.source result
);

	logic                          valid_s1, valid_q;
	logic                          ready_s1, ready_q;
	logic [Q26_W-1:0]              q26_s1;
	logic [LET_W-1:0]              vlo_s1;
	ppr36_chars_t                  chars_s1;
	logic [Q26_IN_W-1:0]           v;
	logic [Q26_IN_W+RECIP26_W-1:0] prod;
	logic [LET_W-1:0]              letter;
	logic [IDX_W-1:0]              idx_q;
	logic [UTF8_W-1:0]             utf8_q;
	logic [CHAR_W-1:0]             series_q;
	ppr36_chars_t                  chars_q;

	assign ready_q  = !valid_q || result.ready;
	assign ready_s1 = !valid_s1 || ready_q;
	assign in_ready = ready_s1;

	assign v = in_word.value[Q26_IN_W-1:0];
	assign prod = {{RECIP26_W{1'b0}}, v} * {{Q26_IN_W{1'b0}}, RECIP26};
	assign letter = vlo_s1 - mul26_lo5(q26_s1[LET_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_q) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			q26_s1   <= prod[RECIP26_SH +: Q26_W];
			vlo_s1   <= v[LET_W-1:0];
			chars_s1 <= in_word.chars;
		end
		if (ready_q && valid_s1) begin
			idx_q    <= q26_s1[IDX_W-1:0];
			utf8_q   <= province_code(q26_s1[IDX_W-1:0]);
			series_q <= ASCII_A + CHAR_W'(letter);
			chars_q  <= chars_s1;
		end
	end

	assign result.valid          = valid_q;
	assign result.province_index = idx_q;
	assign result.province_utf8  = utf8_q;
	assign result.series_letter  = series_q;
	assign result.serial_char_1  = chars_q[4];
	assign result.serial_char_2  = chars_q[3];
	assign result.serial_char_3  = chars_q[2];
	assign result.serial_char_4  = chars_q[1];
	assign result.serial_char_5  = chars_q[0];

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for packed_plate_radix36_decoder; predicts each decoded
// plate word and checks results in order under random idling and a long output stall.
// Depends on ppr36_pkg, ppr36_plate_if, ppr36_result_if and the decoder RTL.

module tb_top import ppr36_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam longint unsigned PLATE_MAX = 64'hF_FFFF_FFFF;
	localparam longint unsigned PROVINCE_STEP = 64'd1572120576;

	typedef struct packed {
		logic [IDX_W-1:0]  province_index;
		logic [UTF8_W-1:0] province_utf8;
		logic [CHAR_W-1:0] series_letter;
		logic [CHAR_W-1:0] serial_char_1;
		logic [CHAR_W-1:0] serial_char_2;
		logic [CHAR_W-1:0] serial_char_3;
		logic [CHAR_W-1:0] serial_char_4;
		logic [CHAR_W-1:0] serial_char_5;
	} decoded_plate_t;

	class plate_scoreboard;
		decoded_plate_t expected_plates[$];
		int errors = 0;
		logic [UTF8_W-1:0] province_table [32] = '{
			24'hE7B2A4, 24'hE6B998, 24'hE4BAAC, 24'hE6B4A5,
			24'hE6B2AA, 24'hE6B89D, 24'hE58680, 24'hE8B1AB,
			24'hE4BA91, 24'hE8BEBD, 24'hE9BB91, 24'hE79A96,
			24'hE9B281, 24'hE696B0, 24'hE88B8F, 24'hE6B599,
			24'hE8B5A3, 24'hE98482, 24'hE6A182, 24'hE79498,
			24'hE6998B, 24'hE89299, 24'hE99995, 24'hE59089,
			24'hE997BD, 24'hE8B4B5, 24'hE99D92, 24'hE8978F,
			24'hE5B79D, 24'hE5AE81, 24'hE790BC, 24'hE58FB0
		};

		function void note_plate(input logic [PLATE_W-1:0] plate);
			logic [PLATE_W-1:0] rest;
			logic [DIG_W-1:0] dig;
			logic [CHAR_W-1:0] chars [NUM_DIG];
			decoded_plate_t d;
			rest = plate;
			for (int k = NUM_DIG - 1; k >= 0; k--) begin
				dig = DIG_W'(rest % 36);
				chars[k] = (dig < 10) ? CHAR_W'(48 + dig) : CHAR_W'(55 + dig);
				rest = rest / 36;
			end
			d.series_letter = CHAR_W'(65 + (rest % 26));
			d.province_index = IDX_W'(rest / 26);
			d.province_utf8 = province_table[d.province_index];
			d.serial_char_1 = chars[0];
			d.serial_char_2 = chars[1];
			d.serial_char_3 = chars[2];
			d.serial_char_4 = chars[3];
			d.serial_char_5 = chars[4];
			expected_plates.push_back(d);
		endfunction

		function void check_result(input decoded_plate_t got);
			decoded_plate_t want;
			if (expected_plates.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result word: idx %0d utf8 %h letter %h chars %h %h %h %h %h",
						got.province_index, got.province_utf8, got.series_letter,
						got.serial_char_1, got.serial_char_2, got.serial_char_3,
						got.serial_char_4, got.serial_char_5);
				end
				return;
			end
			want = expected_plates.pop_front();
			if (got.province_index !== want.province_index
					|| got.province_utf8 !== want.province_utf8
					|| got.series_letter !== want.series_letter
					|| got.serial_char_1 !== want.serial_char_1
					|| got.serial_char_2 !== want.serial_char_2
					|| got.serial_char_3 !== want.serial_char_3
					|| got.serial_char_4 !== want.serial_char_4
					|| got.serial_char_5 !== want.serial_char_5) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch exp: idx %0d utf8 %h letter %h chars %h %h %h %h %h",
						want.province_index, want.province_utf8, want.series_letter,
						want.serial_char_1, want.serial_char_2, want.serial_char_3,
						want.serial_char_4, want.serial_char_5);
					$display("         act: idx %0d utf8 %h letter %h chars %h %h %h %h %h",
						got.province_index, got.province_utf8, got.series_letter,
						got.serial_char_1, got.serial_char_2, got.serial_char_3,
						got.serial_char_4, got.serial_char_5);
				end
			end
		endfunction

		function int pending();
			return expected_plates.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int send_idle_pct = 30;
	int recv_idle_pct = 56;
	bit hold_off_go = 1'b0;
	int quiet_cycles = 0;
	plate_scoreboard plate_sb = new();

	ppr36_plate_if plate_if ();
	ppr36_result_if result_if ();

	packed_plate_radix36_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.plate(plate_if),
		.result(result_if)
	);

	always #10 clk = ~clk;

	function automatic longint unsigned compose_plate(input int q, input int l, input int d1,
			input int d2, input int d3, input int d4, input int d5);
		longint unsigned v;
		v = longint'(q) * 26 + l;
		v = (((((v * 36 + d1) * 36 + d2) * 36 + d3) * 36 + d4) * 36 + d5);
		return v;
	endfunction

	function automatic logic [PLATE_W-1:0] random_plate();
		longint unsigned v;
		if ($urandom_range(0, 1) == 0) begin
			return PLATE_W'({$urandom(), $urandom()});
		end
		v = compose_plate($urandom_range(0, 43), $urandom_range(0, 25),
			$urandom_range(0, 35), $urandom_range(0, 35), $urandom_range(0, 35),
			$urandom_range(0, 35), $urandom_range(0, 35));
		if (v > PLATE_MAX) begin
			v = compose_plate($urandom_range(0, 42), $urandom_range(0, 25),
				$urandom_range(0, 35), $urandom_range(0, 35), $urandom_range(0, 35),
				$urandom_range(0, 35), $urandom_range(0, 35));
		end
		return PLATE_W'(v);
	endfunction

	task automatic send_plate(input logic [PLATE_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			plate_if.valid <= 1'b0;
			@(posedge clk);
		end
		plate_if.valid <= 1'b1;
		plate_if.packed_plate <= v;
		@(posedge clk);
		while (!plate_if.ready) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_plate(random_plate());
		end
	endtask

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		bit hold_taken;
		int hold_left;
		hold_taken = 1'b0;
		hold_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		decoded_plate_t got;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				got.province_index = result_if.province_index;
				got.province_utf8 = result_if.province_utf8;
				got.series_letter = result_if.series_letter;
				got.serial_char_1 = result_if.serial_char_1;
				got.serial_char_2 = result_if.serial_char_2;
				got.serial_char_3 = result_if.serial_char_3;
				got.serial_char_4 = result_if.serial_char_4;
				got.serial_char_5 = result_if.serial_char_5;
				plate_sb.check_result(got);
			end
			if (plate_if.valid && plate_if.ready) begin
				plate_sb.note_plate(plate_if.packed_plate);
			end
		end
	end

	always @(posedge clk) begin
		if ((plate_if.valid && plate_if.ready) || (result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		longint unsigned directed_plates[$];
		directed_plates = '{
			64'd0, PLATE_MAX, 64'hA_AAAA_AAAA, 64'h5_5555_5555,
			64'd9, 64'd10, 64'd35, 64'd36,
			64'd60466175, 64'd60466176, PROVINCE_STEP - 1, PROVINCE_STEP,
			PROVINCE_STEP * 31, PROVINCE_STEP * 32, PROVINCE_STEP * 43,
			PROVINCE_STEP * 32 - 1,
			compose_plate(0, 25, 9, 10, 35, 0, 1),
			compose_plate(21, 12, 35, 9, 10, 36 - 1, 10),
			compose_plate(43, 0, 0, 0, 0, 0, 0) + 64'd1,
			64'h8_0000_0000
		};
		plate_if.valid <= 1'b0;
		plate_if.packed_plate <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plates[i]) begin
			send_plate(PLATE_W'(directed_plates[i]));
		end
		send_random(400);

		send_idle_pct = 56;
		recv_idle_pct = 30;
		send_random(415);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_go = 1'b1;
		send_random(415);
		plate_if.valid <= 1'b0;

		while (plate_sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (plate_sb.errors == 0 && plate_sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
